>>> sv/psalu_pkg.sv
// Package for the 64-bit packed SIMD ALU: operand widths, operation codes,
// the request struct and the signed-word saturation helper.
// No dependencies.
package psalu_pkg;

    localparam int OP_W       = 4;
    localparam int DATA_W     = 64;
    localparam int CNT_W      = 8;
    localparam int BYTE_W     = 8;
    localparam int ALIGN_MAX  = 15;

    typedef enum logic [OP_W-1:0] {
        OP_PABSB     = 4'd0,
        OP_PABSW     = 4'd1,
        OP_PABSD     = 4'd2,
        OP_PALIGNR   = 4'd3,
        OP_PHADDW    = 4'd4,
        OP_PHADDD    = 4'd5,
        OP_PHADDSW   = 4'd6,
        OP_PHSUBW    = 4'd7,
        OP_PHSUBD    = 4'd8,
        OP_PHSUBSW   = 4'd9,
        OP_PMADDUBSW = 4'd10,
        OP_PMULHRSW  = 4'd11,
        OP_PSHUFB    = 4'd12,
        OP_PSIGNB    = 4'd13,
        OP_PSIGNW    = 4'd14,
        OP_PSIGND    = 4'd15
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [DATA_W-1:0] dest_value;
        logic [DATA_W-1:0] src_value;
        logic [CNT_W-1:0]  align_count;
    } alu_req_t;

    function automatic logic [15:0] sat16(input logic signed [17:0] x);
        if (x > 18'sd32767) begin
            return 16'h7fff;
        end
        else if (x < -18'sd32768) begin
            return 16'h8000;
        end
        else begin
            return x[15:0];
        end
    endfunction

endpackage

>>> sv/psalu_if.sv
// Handshake channels of the packed SIMD ALU: request and response.
// Depends on psalu_pkg for the field widths.
interface psalu_in_if
    import psalu_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [DATA_W-1:0] dest_value;
    logic [DATA_W-1:0] src_value;
    logic [CNT_W-1:0]  align_count;

    modport source (output valid, output operation, output dest_value,
                    output src_value, output align_count, input ready);
    modport sink   (input valid, input operation, input dest_value,
                    input src_value, input align_count, output ready);
endinterface

interface psalu_out_if
    import psalu_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] result_value;

    modport source (output valid, output result_value, input ready);
    modport sink   (input valid, input result_value, output ready);
endinterface

>>> sv/psalu_core.sv
// Combinational datapath of the packed SIMD ALU: all sixteen operations.
// Depends on psalu_pkg.
module psalu_core
    import psalu_pkg::*;
(
    input  alu_req_t          req,
    output logic [DATA_W-1:0] result
);

    always_comb
    begin
        logic [DATA_W-1:0]   d;
        logic [DATA_W-1:0]   s;
        logic [DATA_W-1:0]   vsel;
        logic [2*DATA_W-1:0] cat;
        logic signed [15:0]  ha;
        logic signed [15:0]  hb;
        logic signed [16:0]  hsum;
        logic signed [16:0]  p0;
        logic signed [16:0]  p1;
        logic signed [17:0]  mac;
        logic signed [31:0]  prod;
        logic [32:0]         rnd;
        logic [7:0]          sel;
        logic [DATA_W-1:0]   shf;
        d      = req.dest_value;
        s      = req.src_value;
        vsel   = '0;
        cat    = '0;
        ha     = '0;
        hb     = '0;
        hsum   = '0;
        p0     = '0;
        p1     = '0;
        mac    = '0;
        prod   = '0;
        rnd    = '0;
        sel    = '0;
        shf    = '0;
        result = '0;
        case (op_t'(req.operation))
            OP_PABSB:
            begin
                for (int i = 0; i < 8; i++) begin
                    result[i*8 +: 8] = s[i*8+7] ? (8'd0 - s[i*8 +: 8]) : s[i*8 +: 8];
                end
            end
            OP_PABSW:
            begin
                for (int i = 0; i < 4; i++) begin
                    result[i*16 +: 16] = s[i*16+15] ? (16'd0 - s[i*16 +: 16])
                                                    : s[i*16 +: 16];
                end
            end
            OP_PABSD:
            begin
                for (int i = 0; i < 2; i++) begin
                    result[i*32 +: 32] = s[i*32+31] ? (32'd0 - s[i*32 +: 32])
                                                    : s[i*32 +: 32];
                end
            end
            OP_PALIGNR:
            begin
                cat = {d, s} >> {req.align_count[3:0], 3'b000};
                if (req.align_count > CNT_W'(ALIGN_MAX)) begin
                    result = '0;
                end
                else begin
                    result = cat[DATA_W-1:0];
                end
            end
            OP_PHADDW, OP_PHADDSW, OP_PHSUBW, OP_PHSUBSW:
            begin
                for (int i = 0; i < 4; i++) begin
                    vsel = (i < 2) ? d : s;
                    ha   = vsel[(i & 1)*32 +: 16];
                    hb   = vsel[(i & 1)*32 + 16 +: 16];
                    if (req.operation inside {OP_PHADDW, OP_PHADDSW}) begin
                        hsum = {ha[15], ha} + {hb[15], hb};
                    end
                    else begin
                        hsum = {ha[15], ha} - {hb[15], hb};
                    end
                    if (req.operation inside {OP_PHADDSW, OP_PHSUBSW}) begin
                        result[i*16 +: 16] = sat16({hsum[16], hsum});
                    end
                    else begin
                        result[i*16 +: 16] = hsum[15:0];
                    end
                end
            end
            OP_PHADDD:
            begin
                result[31:0]  = d[31:0] + d[63:32];
                result[63:32] = s[31:0] + s[63:32];
            end
            OP_PHSUBD:
            begin
                result[31:0]  = d[31:0] - d[63:32];
                result[63:32] = s[31:0] - s[63:32];
            end
            OP_PMADDUBSW:
            begin
                for (int i = 0; i < 4; i++) begin
                    p0  = $signed({1'b0, d[i*16 +: 8]}) * $signed(s[i*16 +: 8]);
                    p1  = $signed({1'b0, d[i*16+8 +: 8]}) * $signed(s[i*16+8 +: 8]);
                    mac = {p0[16], p0} + {p1[16], p1};
                    result[i*16 +: 16] = sat16(mac);
                end
            end
            OP_PMULHRSW:
            begin
                for (int i = 0; i < 4; i++) begin
                    ha   = d[i*16 +: 16];
                    hb   = s[i*16 +: 16];
                    prod = ha * hb;
                    rnd  = {prod[31], prod} + 33'd16384;
                    result[i*16 +: 16] = rnd[30:15];
                end
            end
            OP_PSHUFB:
            begin
                for (int i = 0; i < 8; i++) begin
                    sel = s[i*8 +: 8];
                    shf = d >> {sel[2:0], 3'b000};
                    result[i*8 +: 8] = sel[7] ? 8'd0 : shf[BYTE_W-1:0];
                end
            end
            OP_PSIGNB:
            begin
                for (int i = 0; i < 8; i++) begin
                    if (s[i*8 +: 8] == 8'd0) begin
                        result[i*8 +: 8] = 8'd0;
                    end
                    else if (s[i*8+7]) begin
                        result[i*8 +: 8] = 8'd0 - d[i*8 +: 8];
                    end
                    else begin
                        result[i*8 +: 8] = d[i*8 +: 8];
                    end
                end
            end
            OP_PSIGNW:
            begin
                for (int i = 0; i < 4; i++) begin
                    if (s[i*16 +: 16] == 16'd0) begin
                        result[i*16 +: 16] = 16'd0;
                    end
                    else if (s[i*16+15]) begin
                        result[i*16 +: 16] = 16'd0 - d[i*16 +: 16];
                    end
                    else begin
                        result[i*16 +: 16] = d[i*16 +: 16];
                    end
                end
            end
            OP_PSIGND:
            begin
                for (int i = 0; i < 2; i++) begin
                    if (s[i*32 +: 32] == 32'd0) begin
                        result[i*32 +: 32] = 32'd0;
                    end
                    else if (s[i*32+31]) begin
                        result[i*32 +: 32] = 32'd0 - d[i*32 +: 32];
                    end
                    else begin
                        result[i*32 +: 32] = d[i*32 +: 32];
                    end
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

>>> sv/packed_simd_alu_64.sv
// Top level of the 64-bit packed SIMD ALU: input register, datapath, result register.
// Depends on psalu_pkg, psalu_in_if, psalu_out_if and psalu_core.
//
//   Channel  Dir  Payload                                              Transaction
//   req      in   operation, dest_value, src_value, align_count        one instruction
//   rsp      out  result_value                                         one 64-bit result
//
// A transaction goes through the input register, then the result register; one
// is accepted every cycle unless both stages are full and the result stalls.
// The single pass through psalu_core sets the clock. Reset empties both stages.
// A stalled result holds in its register while the input register takes one more.
module packed_simd_alu_64
    import psalu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    psalu_in_if.sink     req,
    psalu_out_if.source  rsp
);

    logic              in_valid_reg;
    logic              in_valid_next;
    alu_req_t          in_item_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] result_reg;
    logic [DATA_W-1:0] core_result;
    logic              out_adv;
    logic              in_adv;

    assign out_adv = !out_valid_reg || rsp.ready;
    assign in_adv  = !in_valid_reg || out_adv;

    assign req.ready        = in_adv;
    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = result_reg;

    always_comb
    begin
        in_valid_next  = in_adv ? req.valid : in_valid_reg;
        out_valid_next = out_adv ? in_valid_reg : out_valid_reg;
    end

    psalu_core u_core (
        .req    (in_item_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && in_adv) begin
            in_item_reg.operation   <= req.operation;
            in_item_reg.dest_value  <= req.dest_value;
            in_item_reg.src_value   <= req.src_value;
            in_item_reg.align_count <= req.align_count;
        end
        if (in_valid_reg && out_adv) begin
            result_reg <= core_result;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_adv) |=> out_valid_reg)
        else $error("Input stage transaction did not reach the result register.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> req.ready)
        else $error("Request stalled while the result register was empty.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_adv && in_item_reg.operation == OP_PALIGNR
         && in_item_reg.align_count > CNT_W'(ALIGN_MAX)) |=> (result_reg == '0))
        else $error("Byte align beyond fifteen bytes gave a nonzero result.");

endmodule
